/* rtl/core/square_period_write_sequencer_top_defines.svh */
// assertion macros used by the write sequencer back end
`ifndef SQUARE_PERIOD_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define SQUARE_PERIOD_WRITE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define SPWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define SPWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPWS_ASSERT_IMP(lbl, ante, cons, msg)
`define SPWS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/spws_pkg.sv */
// types and constants of the square period write sequencer
package spws_pkg;

  localparam logic CMD_SET     = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  localparam logic [4:0] ADDR_VOL   = 5'h00;
  localparam logic [4:0] ADDR_SWEEP = 5'h01;
  localparam logic [4:0] ADDR_LO    = 5'h02;
  localparam logic [4:0] ADDR_HI    = 5'h03;
  localparam logic [4:0] ADDR_MODE  = 5'h17;
  localparam logic [4:0] ADDR_END   = 5'h1F;

  localparam logic [7:0] CTRL_FIXED   = 8'h30;
  localparam logic [7:0] MODE_ENTER   = 8'h40;
  localparam logic [7:0] MODE_EXIT    = 8'hC0;
  localparam logic [7:0] SWEEP_UP     = 8'h87;
  localparam logic [7:0] SWEEP_DOWN   = 8'h8F;
  localparam logic [7:0] SWEEP_OFF    = 8'h0F;
  localparam logic [7:0] LO_FILL_UP   = 8'hFF;
  localparam logic [7:0] LO_FILL_DOWN = 8'h00;
  localparam logic [7:0] END_DATA     = 8'h00;

  localparam logic [2:0] PHASE_LAST = 3'd4;

  typedef struct packed {
    logic        refresh;
    logic        held;
    logic        up;
    logic        changed;
    logic [2:0]  steps;
    logic [7:0]  ctrl;
    logic [10:0] period;
  } spws_desc_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_CTRL,
    ST_HIGH,
    ST_STEP,
    ST_LOW,
    ST_END
  } spws_state_t;

endpackage

/* rtl/core/spws_front.sv */
// front end: classifies each command and tracks the current period
module spws_front import spws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        cmd,
  input  logic [10:0] new_period,
  input  logic        notes_held,
  input  logic [3:0]  volume,
  input  logic [1:0]  duty,
  output spws_desc_t  desc
);

  logic [10:0] current_period;
  logic [2:0]  new_hi;
  logic [2:0]  cur_hi;
  logic        rising;

  assign new_hi = new_period[10:8];
  assign cur_hi = current_period[10:8];
  assign rising = new_period > current_period;

  always_comb begin
    desc.refresh = (cmd == CMD_REFRESH);
    desc.held    = notes_held;
    desc.up      = rising;
    desc.changed = (new_period != current_period);
    desc.steps   = rising ? (new_hi - cur_hi) : (cur_hi - new_hi);
    desc.ctrl    = {duty, 2'b00, volume} | CTRL_FIXED;
    desc.period  = new_period;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_period <= 11'd0;
    end else if (accept && (cmd == CMD_SET)) begin
      current_period <= new_period;
    end
  end

endmodule

/* rtl/core/spws_queue.sv */
// small descriptor queue between front and back end
module spws_queue import spws_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  spws_desc_t wr_desc,
  output logic       q_full,
  input  logic       rd_en,
  output spws_desc_t rd_desc,
  output logic       rd_valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  spws_desc_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full   = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_desc  = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/spws_back.sv */
// back end: expands one descriptor into register writes
module spws_back import spws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  spws_desc_t head,
  input  logic       head_valid,
  output logic       head_pop,
  input  logic       pop,
  output logic       empty,
  output logic [4:0] reg_addr,
  output logic [7:0] reg_data,
  output logic       last_write
);

`include "square_period_write_sequencer_top_defines.svh"

  spws_state_t state;
  spws_state_t state_next;
  spws_state_t entry;
  spws_state_t sel;
  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [2:0]  step_idx;
  logic [2:0]  step_idx_next;
  logic        out_valid;
  logic        adv;
  logic        go;
  logic [4:0]  wr_addr;
  logic [7:0]  wr_data;
  logic        wr_last;

  assign empty = !out_valid;
  assign adv   = !out_valid || pop;
  assign go    = adv && head_valid;

  // first write kind of a fresh descriptor
  always_comb begin
    if (head.refresh || !head.held) begin
      entry = ST_CTRL;
    end else if (head.steps != 3'd0) begin
      entry = ST_STEP;
    end else begin
      entry = ST_LOW;
    end
  end

  assign sel      = (state == ST_START) ? entry : state;
  assign head_pop = go && (sel == ST_END);

  // write selected by the current step
  always_comb begin
    wr_addr = ADDR_END;
    wr_data = END_DATA;
    wr_last = 1'b0;
    case (sel)
      ST_CTRL: begin
        wr_addr = ADDR_VOL;
        wr_data = head.ctrl;
      end
      ST_HIGH: begin
        wr_addr = ADDR_HI;
        wr_data = {5'd0, head.period[10:8]};
      end
      ST_STEP: begin
        case (phase)
          3'd0: begin
            wr_addr = ADDR_MODE;
            wr_data = MODE_ENTER;
          end
          3'd1: begin
            wr_addr = ADDR_LO;
            wr_data = head.up ? LO_FILL_UP : LO_FILL_DOWN;
          end
          3'd2: begin
            wr_addr = ADDR_SWEEP;
            wr_data = head.up ? SWEEP_UP : SWEEP_DOWN;
          end
          3'd3: begin
            wr_addr = ADDR_MODE;
            wr_data = MODE_EXIT;
          end
          default: begin
            wr_addr = ADDR_SWEEP;
            wr_data = SWEEP_OFF;
          end
        endcase
      end
      ST_LOW: begin
        wr_addr = ADDR_LO;
        wr_data = head.period[7:0];
      end
      ST_END: begin
        wr_addr = ADDR_END;
        wr_data = END_DATA;
        wr_last = 1'b1;
      end
      default: begin
        wr_addr = ADDR_END;
        wr_data = END_DATA;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    step_idx_next = step_idx;
    if (go) begin
      phase_next    = 3'd0;
      step_idx_next = 3'd0;
      case (sel)
        ST_CTRL: begin
          if (head.refresh) begin
            state_next = ST_END;
          end else if (head.changed) begin
            state_next = ST_HIGH;
          end else begin
            state_next = ST_LOW;
          end
        end
        ST_HIGH: state_next = ST_LOW;
        ST_STEP: begin
          state_next = ST_STEP;
          if (phase != PHASE_LAST) begin
            phase_next    = phase + 3'd1;
            step_idx_next = step_idx;
          end else if (step_idx == head.steps - 3'd1) begin
            state_next = ST_LOW;
          end else begin
            step_idx_next = step_idx + 3'd1;
          end
        end
        ST_LOW:  state_next = ST_END;
        ST_END:  state_next = ST_START;
        default: state_next = ST_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      phase     <= 3'd0;
      step_idx  <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      step_idx <= step_idx_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      reg_addr   <= wr_addr;
      reg_data   <= wr_data;
      last_write <= wr_last;
    end
  end

  `SPWS_ASSERT_IMP(a_last_at_end, out_valid && last_write, reg_addr == ADDR_END, "last word not at end address")
  `SPWS_ASSERT_IMP(a_phase_range, state == ST_STEP, phase <= PHASE_LAST, "sweep phase out of range")
  `SPWS_ASSERT_IMP(a_step_bound, state == ST_STEP, head_valid && (step_idx < head.steps), "sweep count overrun")
  `SPWS_ASSERT_IMP(a_mid_head, state != ST_START, head_valid, "descriptor lost mid sequence")
  `SPWS_ASSERT_NXT(a_pop_restart, head_pop, state == ST_START, "pop without restart")

endmodule

/* rtl/core/square_period_write_sequencer_top.sv */
// top level of the square period write sequencer
// usage:
// - input side is a queue: drive cmd, new_period, notes_held, volume, duty
//   and raise push; the word is taken on a clock edge with push high and
//   full low
// - output side is a queue: while empty is low, reg_addr / reg_data /
//   last_write show the oldest register write; raise pop to take it
// - every command turns into 2 to 37 writes; last_write marks the closing
//   write to the end address
// - when the block is idle, a taken command is written into the descriptor
//   queue; its first write is then registered in the back end output
//   register, where it shows on the output ports and can be popped
// - throughput: one write per cycle out of the back end while the receiver
//   pops each write
// - the front end classifies and updates the stored period at once, so up to
//   QUEUE_DEPTH commands wait in the descriptor queue while the back end runs
// - when the receiver stalls, the output register holds its write, the back
//   end waits and full rises once the queue fills
// - reset (rst, synchronous) clears the stored period to zero, empties the
//   queue and the output register
module square_period_write_sequencer_top import spws_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [10:0] new_period,
  input  logic        notes_held,
  input  logic [3:0]  volume,
  input  logic [1:0]  duty,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  reg_addr,
  output logic [7:0]  reg_data,
  output logic        last_write
);

  spws_desc_t front_desc;  // classified command from the front end
  spws_desc_t head_desc;   // oldest queued command
  logic       head_valid;
  logic       head_pop;
  logic       accept;

  // a word is taken whenever push is high and the queue has room
  assign accept = push && !full;

  spws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .new_period (new_period),
    .notes_held (notes_held),
    .volume     (volume),
    .duty       (duty),
    .desc       (front_desc)
  );

  // decouples classification from the write expansion
  spws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_desc  (front_desc),
    .q_full   (full),
    .rd_en    (head_pop),
    .rd_desc  (head_desc),
    .rd_valid (head_valid)
  );

  // one write per cycle, while the receiver pops, into a single output register
  spws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_desc),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .reg_addr   (reg_addr),
    .reg_data   (reg_data),
    .last_write (last_write)
  );

endmodule
